// File: src/llm_pkg.sv
package llm_pkg;

  typedef enum logic [2:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_END   = 3'd1,
    OP_INS_AFTER = 3'd2,
    OP_DEL_FRONT = 3'd3,
    OP_DEL_END   = 3'd4,
    OP_DEL_KEY   = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_NOKEY = 2'd3
  } status_e;

  localparam int unsigned OpWidth     = 3;
  localparam int unsigned StatusWidth = 2;
  localparam int unsigned FieldWidth  = 32;

  // Datapath commands issued by the controller.
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,       // capture request, start read of head
    CMD_READ_HEAD,  // read node at head
    CMD_STEP,       // follow link: prev <= cur, cur <= next, read next
    CMD_RD_CUR,     // re-read node at cur
    CMD_INS_FRONT,
    CMD_INS_END,
    CMD_INS_AFTER,
    CMD_DEL_FRONT,
    CMD_DEL_END,
    CMD_DEL_KEY
  } cmd_e;

  typedef struct packed {
    logic head_null;
    logic pool_full;
    logic key_match;
    logic next_null;
    logic walk_done;
  } dp_status_t;

endpackage

// File: src/linked_list_manager.sv
// Singly linked list manager.
// Input channel: op_i, search_key_i, new_value_i with in_valid_i/in_ready_o.
// Output channel: status_o, list_length_o with out_valid_o/out_ready_i.
// One request is handled at a time; in_ready_o is high while the block is
// idle and its result register is free.
// Front operations and insert at end pass through S_RD, S_EXEC and S_GAP
// to S_OUT, where out_valid_o is raised.
// Key searches and delete at end pass through S_RD, then walk the list in
// S_WALK one node-store read per cycle, then go through S_GAP to S_OUT.
// The walk through the node store, a registered-read RAM, sets how long
// such a request takes.
// Reset clears the head and tail pointers, the allocation map and the count;
// the node stores need no clearing since a node is read only after it is
// written. A finished result stays in the output register until taken;
// while the receiver stalls no new request is accepted.
module linked_list_manager #(
  parameter int unsigned NODES       = 64,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [llm_pkg::OpWidth-1:0]       op_i,
  input  logic [llm_pkg::FieldWidth-1:0]    search_key_i,
  input  logic [llm_pkg::FieldWidth-1:0]    new_value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [llm_pkg::StatusWidth-1:0]   status_o,
  output logic [$clog2(NODES+1)-1:0]        list_length_o
);
  import llm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_WALK, S_EXEC, S_GAP, S_OUT
  } state_e;

  state_e state_q;
  logic [OpWidth-1:0] op_q;
  logic [StatusWidth-1:0] st_q;
  cmd_e cmd;
  dp_status_t dps;
  logic [$clog2(NODES+1)-1:0] cnt;

  llm_datapath #(.Nodes(NODES), .ValueWidth(VALUE_WIDTH)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .search_key_i, .new_value_i,
    .status_o(dps), .count_o(cnt)
  );

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = (state_q == S_OUT);
  assign status_o      = st_q;
  assign list_length_o = cnt;

  logic walk_op;
  assign walk_op = (op_q == OP_INS_AFTER) || (op_q == OP_DEL_KEY) || (op_q == OP_DEL_END);

  always_comb begin
    cmd = CMD_NONE;
    unique case (state_q)
      S_IDLE: if (in_valid_i) cmd = CMD_LOAD;
      S_WALK: begin
        if (op_q == OP_DEL_END) begin
          if (!dps.next_null && !dps.walk_done) cmd = CMD_STEP;
          else cmd = CMD_DEL_END;
        end else if (dps.key_match) begin
          if (op_q == OP_DEL_KEY) cmd = CMD_DEL_KEY;
          else if (!dps.pool_full) cmd = CMD_INS_AFTER;
        end else if (!dps.next_null && !dps.walk_done) begin
          cmd = CMD_STEP;
        end
      end
      S_EXEC: begin
        unique case (op_q)
          OP_INS_FRONT: if (!dps.pool_full) cmd = CMD_INS_FRONT;
          OP_INS_END:   if (!dps.pool_full) cmd = CMD_INS_END;
          OP_DEL_FRONT: if (!dps.head_null) cmd = CMD_DEL_FRONT;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= '0;
      st_q    <= ST_DONE;
    end else begin
      unique case (state_q)
        S_IDLE: if (in_valid_i) begin
          op_q    <= op_i;
          st_q    <= ST_DONE;
          state_q <= S_RD;
        end
        S_RD: begin
          if (walk_op) begin
            if (dps.head_null) begin
              st_q    <= (op_q == OP_INS_AFTER) ? ST_NOKEY : ST_EMPTY;
              state_q <= S_GAP;
            end else begin
              state_q <= S_WALK;
            end
          end else begin
            state_q <= S_EXEC;
          end
        end
        S_WALK: begin
          if (op_q == OP_DEL_END) begin
            if (dps.next_null || dps.walk_done) state_q <= S_GAP;
          end else if (dps.key_match) begin
            if (op_q == OP_INS_AFTER && dps.pool_full) st_q <= ST_FULL;
            state_q <= S_GAP;
          end else if (dps.next_null || dps.walk_done) begin
            st_q    <= ST_NOKEY;
            state_q <= S_GAP;
          end
        end
        S_EXEC: begin
          unique case (op_q)
            OP_INS_FRONT, OP_INS_END: if (dps.pool_full) st_q <= ST_FULL;
            OP_DEL_FRONT: if (dps.head_null) st_q <= ST_EMPTY;
            default: ;
          endcase
          state_q <= S_GAP;
        end
        S_GAP: state_q <= S_OUT;
        S_OUT: if (out_ready_i) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

// File: src/llm_ram.sv
module llm_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// File: src/llm_datapath.sv
module llm_datapath #(
  parameter int unsigned Nodes      = 64,
  parameter int unsigned ValueWidth = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  llm_pkg::cmd_e                   cmd_i,
  input  logic [llm_pkg::FieldWidth-1:0]  search_key_i,
  input  logic [llm_pkg::FieldWidth-1:0]  new_value_i,
  output llm_pkg::dp_status_t             status_o,
  output logic [$clog2(Nodes+1)-1:0]      count_o
);
  import llm_pkg::*;

  localparam int unsigned IdxW = $clog2(Nodes);
  localparam int unsigned PtrW = $clog2(Nodes + 1);
  localparam logic [PtrW-1:0] NullPtr = PtrW'(Nodes);

  logic [ValueWidth-1:0] key_q, val_q;
  logic [PtrW-1:0] head_q, tail_q, cur_q, prev_q, free_q;
  logic [PtrW-1:0] cnt_q, steps_q;
  logic [Nodes-1:0] used_q;

  logic            v_we, n_we;
  logic [IdxW-1:0] v_wa, n_wa, raddr;
  logic [ValueWidth-1:0] v_wd, v_rd;
  logic [PtrW-1:0] n_wd, n_rd;

  llm_ram #(.Width(ValueWidth), .Depth(Nodes)) u_val (
    .clk_i, .we_i(v_we), .waddr_i(v_wa), .wdata_i(v_wd),
    .raddr_i(raddr), .rdata_o(v_rd)
  );

  // Lowest free node, found by a priority scan of the allocation map.
  logic [PtrW-1:0] free_idx;
  always_comb begin
    free_idx = NullPtr;
    for (int i = Nodes - 1; i >= 0; i--) begin
      if (!used_q[i]) free_idx = PtrW'(i);
    end
  end

  logic [ValueWidth-1:0] key_ext, val_ext;
  always_comb begin
    key_ext = ValueWidth'($signed(search_key_i));
    val_ext = ValueWidth'($signed(new_value_i));
  end

  always_comb begin
    unique case (cmd_i)
      CMD_LOAD:      raddr = head_q[IdxW-1:0];
      CMD_STEP:      raddr = n_rd[IdxW-1:0];
      CMD_RD_CUR:    raddr = cur_q[IdxW-1:0];
      default:       raddr = head_q[IdxW-1:0];
    endcase
  end

  always_comb begin
    v_we = 1'b0;
    n_we = 1'b0;
    v_wa = free_q[IdxW-1:0];
    n_wa = free_q[IdxW-1:0];
    v_wd = val_q;
    n_wd = NullPtr;
    unique case (cmd_i)
      CMD_INS_FRONT: begin
        v_we = 1'b1; n_we = 1'b1; n_wd = head_q;
      end
      CMD_INS_END: begin
        v_we = 1'b1; n_we = 1'b1; n_wd = NullPtr;
      end
      CMD_INS_AFTER: begin
        v_we = 1'b1; n_we = 1'b1; n_wd = n_rd;
      end
      default: ;
    endcase
  end

  assign status_o.head_null = (head_q == NullPtr);
  assign status_o.pool_full = (free_q == NullPtr);
  assign status_o.key_match = (v_rd == key_q);
  assign status_o.next_null = (n_rd >= NullPtr);
  assign status_o.walk_done = (steps_q >= PtrW'(Nodes));
  assign count_o = cnt_q;

  // Second write port on the link store is avoided: link updates of an
  // existing node are done as a separate write through the new-node port
  // pattern below.
  logic            lk_we;
  logic [IdxW-1:0] lk_wa;
  logic [PtrW-1:0] lk_wd;
  always_comb begin
    lk_we = 1'b0;
    lk_wa = tail_q[IdxW-1:0];
    lk_wd = free_q;
    unique case (cmd_i)
      CMD_DEL_END: begin
        lk_we = (prev_q != NullPtr); lk_wa = prev_q[IdxW-1:0]; lk_wd = NullPtr;
      end
      CMD_DEL_KEY: begin
        lk_we = (prev_q != NullPtr); lk_wa = prev_q[IdxW-1:0]; lk_wd = n_rd;
      end
      default: ;
    endcase
  end

  // Pending link write to an existing node, done in the next cycle.
  logic            pend_q;
  logic [IdxW-1:0] pend_a_q;
  logic [PtrW-1:0] pend_d_q;
  logic            use_pend;
  assign use_pend = pend_q && !n_we;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= NullPtr;
      tail_q  <= NullPtr;
      used_q  <= '0;
      cnt_q   <= '0;
      cur_q   <= NullPtr;
      prev_q  <= NullPtr;
      free_q  <= NullPtr;
      steps_q <= '0;
      pend_q  <= 1'b0;
    end else begin
      unique case (cmd_i)
        CMD_LOAD: begin
          key_q   <= key_ext;
          val_q   <= val_ext;
          free_q  <= free_idx;
          cur_q   <= head_q;
          prev_q  <= NullPtr;
          steps_q <= '0;
        end
        CMD_STEP: begin
          prev_q  <= cur_q;
          cur_q   <= n_rd;
          steps_q <= steps_q + 1'b1;
        end
        CMD_INS_FRONT: begin
          used_q[free_q[IdxW-1:0]] <= 1'b1;
          cnt_q <= cnt_q + 1'b1;
          head_q <= free_q;
          if (tail_q == NullPtr) tail_q <= free_q;
        end
        CMD_INS_END: begin
          used_q[free_q[IdxW-1:0]] <= 1'b1;
          cnt_q <= cnt_q + 1'b1;
          tail_q <= free_q;
          if (head_q == NullPtr || tail_q == NullPtr) begin
            head_q <= free_q;
          end else begin
            pend_q <= 1'b1; pend_a_q <= tail_q[IdxW-1:0]; pend_d_q <= free_q;
          end
        end
        CMD_INS_AFTER: begin
          used_q[free_q[IdxW-1:0]] <= 1'b1;
          cnt_q <= cnt_q + 1'b1;
          pend_q <= 1'b1; pend_a_q <= cur_q[IdxW-1:0]; pend_d_q <= free_q;
          if (tail_q == cur_q) tail_q <= free_q;
        end
        CMD_DEL_FRONT: begin
          used_q[head_q[IdxW-1:0]] <= 1'b0;
          if (cnt_q != '0) cnt_q <= cnt_q - 1'b1;
          if (n_rd >= NullPtr) begin
            head_q <= NullPtr; tail_q <= NullPtr;
          end else begin
            head_q <= n_rd;
          end
        end
        CMD_DEL_END: begin
          used_q[cur_q[IdxW-1:0]] <= 1'b0;
          if (cnt_q != '0) cnt_q <= cnt_q - 1'b1;
          if (prev_q == NullPtr) begin
            head_q <= NullPtr; tail_q <= NullPtr;
          end else begin
            tail_q <= prev_q;
            pend_q <= lk_we; pend_a_q <= lk_wa; pend_d_q <= lk_wd;
          end
        end
        CMD_DEL_KEY: begin
          used_q[cur_q[IdxW-1:0]] <= 1'b0;
          if (cnt_q != '0) cnt_q <= cnt_q - 1'b1;
          if (prev_q == NullPtr) begin
            if (n_rd >= NullPtr) begin
              head_q <= NullPtr; tail_q <= NullPtr;
            end else begin
              head_q <= n_rd;
              if (tail_q == cur_q) tail_q <= prev_q;
            end
          end else begin
            pend_q <= lk_we; pend_a_q <= lk_wa; pend_d_q <= lk_wd;
            if (tail_q == cur_q) tail_q <= prev_q;
          end
        end
        default: if (use_pend) pend_q <= 1'b0;
      endcase
    end
  end

  // The link store is written by the new-node path, or by the pending link
  // update in the following cycle (the controller always passes through S_GAP,
  // where it issues no command, after an update).
  logic            nx_we;
  logic [IdxW-1:0] nx_wa;
  logic [PtrW-1:0] nx_wd;
  always_comb begin
    nx_we = n_we | use_pend;
    nx_wa = n_we ? n_wa : pend_a_q;
    nx_wd = n_we ? n_wd : pend_d_q;
  end

  llm_ram #(.Width(PtrW), .Depth(Nodes)) u_next (
    .clk_i, .we_i(nx_we), .waddr_i(nx_wa), .wdata_i(nx_wd),
    .raddr_i(raddr), .rdata_o(n_rd)
  );
endmodule

// File: test/testbench.sv
module testbench;
  import llm_pkg::*;

  localparam int Nodes = 64;
  localparam int NullLink = Nodes;
  localparam int RandItems = 1200;
  localparam int WatchdogLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [OpWidth-1:0] op_i = '0;
  logic [FieldWidth-1:0] search_key_i = '0;
  logic [FieldWidth-1:0] new_value_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [StatusWidth-1:0] status_o;
  logic [6:0] list_length_o;

  always #5 clk_i = ~clk_i;

  linked_list_manager u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .op_i(op_i), .search_key_i(search_key_i), .new_value_i(new_value_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
    .status_o(status_o), .list_length_o(list_length_o)
  );

  typedef struct packed {
    status_e status;
    logic [6:0] length;
  } list_result_t;

  // Shadow of the list kept as an ordered queue of values; the pool only
  // matters through its capacity, since lowest-free allocation is invisible.
  class list_scoreboard;
    logic [31:0] shadow_list[$];
    list_result_t pending[$];
    int errors;
    int checked;
    int status_seen[4];

    function int find_value(logic [31:0] key);
      foreach (shadow_list[i]) if (shadow_list[i] == key) return i;
      return -1;
    endfunction

    function void note_request(op_e op, logic [31:0] key, logic [31:0] val);
      list_result_t r;
      int pos;
      r.status = ST_DONE;
      case (op)
        OP_INS_FRONT, OP_INS_END: begin
          if (shadow_list.size() >= Nodes) r.status = ST_FULL;
          else if (op == OP_INS_FRONT) shadow_list.push_front(val);
          else shadow_list.push_back(val);
        end
        OP_INS_AFTER: begin
          pos = find_value(key);
          if (pos < 0) r.status = ST_NOKEY;
          else if (shadow_list.size() >= Nodes) r.status = ST_FULL;
          else shadow_list.insert(pos + 1, val);
        end
        OP_DEL_FRONT, OP_DEL_END: begin
          if (shadow_list.size() == 0) r.status = ST_EMPTY;
          else if (op == OP_DEL_FRONT) void'(shadow_list.pop_front());
          else void'(shadow_list.pop_back());
        end
        OP_DEL_KEY: begin
          pos = find_value(key);
          if (shadow_list.size() == 0) r.status = ST_EMPTY;
          else if (pos < 0) r.status = ST_NOKEY;
          else shadow_list.delete(pos);
        end
        default: ;
      endcase
      r.length = 7'(shadow_list.size());
      pending.push_back(r);
    endfunction

    function void check_result(logic [1:0] status, logic [6:0] length);
      list_result_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result status=%0d length=%0d", $time, status, length);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      status_seen[status]++;
      if (status !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, status);
        errors++;
      end
      if (length !== e.length) begin
        $display("%0t: length expected %0d actual %0d", $time, e.length, length);
        errors++;
      end
    endfunction
  endclass

  list_scoreboard sb;
  int idle_pct = 30;
  int stall_cycles;

  // Picks a key that is in the list most of the time, so searches go deep.
  function automatic logic [31:0] pick_key();
    if (sb.shadow_list.size() > 0 && $urandom_range(0, 3) != 0)
      return sb.shadow_list[$urandom_range(0, sb.shadow_list.size() - 1)];
    return $urandom();
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer
  // with valid still high, so the caller either sends again or drops it.
  task automatic send_request(op_e op, logic [31:0] key, logic [31:0] val);
    while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    op_i <= op;
    search_key_i <= key;
    new_value_i <= val;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(op, key, val);
    stall_cycles = 0;
    @(negedge clk_i);
  endtask

  always @(negedge clk_i)
    out_ready_i <= (idle_pct == 0) || ($urandom_range(0, 99) >= idle_pct);

  always @(posedge clk_i)
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        sb.check_result(status_o, list_length_o);
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= WatchdogLimit) begin
          $display("Watchdog expired with %0d results pending", sb.pending.size());
          $display("SCOREBOARD MISMATCH");
          $finish;
        end
      end
    end

  logic [31:0] extremes[4] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff};
  int k;
  op_e rop;

  initial begin
    sb = new();
    stall_cycles = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: operations on an empty list, extreme values, key ops.
    send_request(OP_DEL_FRONT, 0, 0);
    send_request(OP_DEL_END, 0, 0);
    send_request(OP_DEL_KEY, 0, 0);
    send_request(OP_INS_AFTER, 0, 1);
    for (k = 0; k < 4; k++) send_request(OP_INS_END, 0, extremes[k]);
    send_request(OP_INS_FRONT, 0, 32'h1234_5678);
    send_request(OP_INS_AFTER, 32'h7fff_ffff, 32'h5555_5555);
    send_request(OP_INS_AFTER, 32'hffff_ffff, 32'haaaa_aaaa);
    send_request(OP_INS_AFTER, 32'h0bad_0bad, 1);
    send_request(OP_DEL_KEY, 32'haaaa_aaaa, 0);
    send_request(OP_DEL_KEY, 32'h1234_5678, 0);
    send_request(OP_DEL_KEY, 32'h0bad_0bad, 0);
    send_request(OP_DEL_END, 0, 0);
    send_request(OP_DEL_FRONT, 0, 0);
    // Fill the pool, then insert into it full, including after a key.
    while (sb.shadow_list.size() < Nodes) send_request(OP_INS_END, 0, $urandom());
    idle_pct = 30;
    send_request(OP_INS_FRONT, 0, 7);
    send_request(OP_INS_END, 0, 7);
    send_request(OP_INS_AFTER, sb.shadow_list[Nodes - 1], 7);
    send_request(OP_INS_AFTER, 32'h0bad_0bad, 7);
    // Delete half the list from the end, then delete the rest by key.
    for (k = 0; k < 32; k++) send_request(OP_DEL_END, 0, 0);
    while (sb.shadow_list.size() > 0) send_request(OP_DEL_KEY, pick_key(), 0);

    // Random part: insert and delete ops are picked with equal odds throughout.
    for (k = 0; k < RandItems; k++) begin
      idle_pct = (k >= 400 && k < 550) ? 0 : 30;
      if ($urandom_range(0, 1) == 0 ^ ((k / 200) % 2 == 0))
        rop = op_e'($urandom_range(0, 2));
      else
        rop = op_e'($urandom_range(3, 5));
      send_request(rop, pick_key(),
                   ($urandom_range(0, 4) == 0) ? $urandom_range(0, 7) : $urandom());
    end
    in_valid_i <= 1'b0;
    idle_pct = 30;

    while (sb.pending.size() > 0) @(posedge clk_i);
    repeat (Nodes + 10) @(posedge clk_i);
    $display("Checked %0d results: %0d done, %0d full, %0d empty, %0d key missing",
             sb.checked, sb.status_seen[0], sb.status_seen[1], sb.status_seen[2],
             sb.status_seen[3]);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// File: sim.f
src/llm_pkg.sv
src/llm_ram.sv
src/llm_datapath.sv
src/linked_list_manager.sv
test/testbench.sv
